// ===== rtl/core/brs_pkg.sv =====
// Shared types and constants for the byte randomness statistics block.
package brs_pkg;

  localparam int unsigned GroupBytes = 6;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned BinCount   = 256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic [39:0] byte_sum;
    logic [47:0] byte_square_sum;
    logic [47:0] circular_lag_sum;
    logic [63:0] bin_square_sum;
    logic [29:0] monte_trials;
    logic [29:0] monte_hits;
    logic        full_res;
  } out_item_t;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic [39:0] byte_sum;
    logic [47:0] byte_square_sum;
    logic [47:0] circular_lag_sum;
    logic        full_res;
  } sums_t;

  typedef struct packed {
    logic       fire;
    logic       restart;
    logic [7:0] data_byte;
  } step_t;

endpackage

// ===== rtl/core/brs_hist.sv =====
// Histogram memory with read-modify-write forwarding and squared-count sum.
module brs_hist #(
  parameter int unsigned COUNT_BITS = brs_pkg::CountBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    rd_addr_i,
  input  brs_pkg::step_t step_i,
  input  logic          counted_i,
  output logic [63:0]   bin_sq_o
);

  localparam int unsigned Bins = brs_pkg::BinCount;

  logic [COUNT_BITS-1:0] mem_q [Bins];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [Bins-1:0]       valid_q, valid_d;
  logic                  fwd_valid_q;
  logic [7:0]            fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [63:0]           sq_q, sq_base;
  logic [COUNT_BITS-1:0] count_cur, count_new;
  logic                  wr_en;

  assign wr_en = step_i.fire && counted_i;

  always_comb begin
    if (step_i.restart) begin
      count_cur = '0;
    end else if (fwd_valid_q && (fwd_addr_q == step_i.data_byte)) begin
      count_cur = fwd_data_q;
    end else if (valid_q[step_i.data_byte]) begin
      count_cur = rdata_q;
    end else begin
      count_cur = '0;
    end
  end

  assign count_new = count_cur + 1'b1;
  assign sq_base   = step_i.restart ? 64'd0 : sq_q;
  assign bin_sq_o  = counted_i ? sq_base + 64'({count_cur, 1'b1}) : sq_q;

  always_comb begin
    valid_d = step_i.restart ? '0 : valid_q;
    valid_d[step_i.data_byte] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[step_i.data_byte] <= count_new;
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= step_i.data_byte;
    fwd_data_q <= count_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
      sq_q        <= '0;
    end else begin
      fwd_valid_q <= wr_en;
      if (wr_en) begin
        valid_q <= valid_d;
      end
      if (step_i.fire) begin
        sq_q <= bin_sq_o;
      end
    end
  end

endmodule

// ===== rtl/core/brs_stats.sv =====
// Scalar running sums, lag products, count bound and coordinate group assembly.
module brs_stats #(
  parameter int unsigned GROUP_BYTES = brs_pkg::GroupBytes,
  parameter int unsigned COUNT_BITS  = brs_pkg::CountBits,
  localparam int unsigned HalfBytes  = GROUP_BYTES / 2,
  localparam int unsigned CoordBits  = 8 * HalfBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brs_pkg::step_t       step_i,
  output logic                 counted_o,
  output brs_pkg::sums_t       sums_o,
  output logic [CoordBits-1:0] x_o,
  output logic [CoordBits-1:0] y_o,
  output logic                 group_done_o
);

  localparam int unsigned PosBits = $clog2(GROUP_BYTES);

  logic [COUNT_BITS-1:0] total_q, total_b, total_n;
  logic [39:0]           vsum_q, vsum_b, vsum_n;
  logic [47:0]           ssum_q, ssum_b, ssum_n;
  logic [47:0]           lag_q, lag_b, lag_n;
  logic                  pend_q, pend_b, pend_n;
  logic [7:0]            first_q, first_b, first_n;
  logic [7:0]            prev_q, prev_b, prev_n;
  logic                  full_q, full_n;
  logic [PosBits-1:0]    pos_q, pos_b, pos_n;
  logic [7:0]            grp_q [GROUP_BYTES];
  logic [7:0]            grp_now [GROUP_BYTES];
  logic [15:0]           sq_term, lag_term, wrap_term;
  logic [7:0]            b;
  logic                  counted, done;

  assign b       = step_i.data_byte;
  assign counted = step_i.restart || !full_q;

  assign total_b = step_i.restart ? '0 : total_q;
  assign vsum_b  = step_i.restart ? '0 : vsum_q;
  assign ssum_b  = step_i.restart ? '0 : ssum_q;
  assign lag_b   = step_i.restart ? '0 : lag_q;
  assign pend_b  = step_i.restart ? 1'b1 : pend_q;
  assign first_b = step_i.restart ? '0 : first_q;
  assign prev_b  = step_i.restart ? '0 : prev_q;
  assign pos_b   = step_i.restart ? '0 : pos_q;

  assign sq_term   = b * b;
  assign lag_term  = pend_b ? 16'd0 : prev_b * b;
  assign wrap_term = prev_n * first_n;
  assign done      = counted && (pos_b == PosBits'(GROUP_BYTES - 1));

  always_comb begin
    for (int k = 0; k < GROUP_BYTES; k++) begin
      grp_now[k] = grp_q[k];
    end
    grp_now[pos_b] = b;
  end

  always_comb begin
    if (counted) begin
      total_n = total_b + 1'b1;
      vsum_n  = vsum_b + 40'(b);
      ssum_n  = ssum_b + 48'(sq_term);
      lag_n   = lag_b + 48'(lag_term);
      pend_n  = 1'b0;
      first_n = pend_b ? b : first_b;
      prev_n  = b;
      full_n  = &total_n;
      pos_n   = done ? '0 : pos_b + 1'b1;
    end else begin
      total_n = total_q;
      vsum_n  = vsum_q;
      ssum_n  = ssum_q;
      lag_n   = lag_q;
      pend_n  = pend_q;
      first_n = first_q;
      prev_n  = prev_q;
      full_n  = full_q;
      pos_n   = pos_q;
    end
  end

  always_comb begin
    for (int k = 0; k < HalfBytes; k++) begin
      x_o[CoordBits-1-8*k -: 8] = grp_now[k];
      y_o[CoordBits-1-8*k -: 8] = grp_now[HalfBytes+k];
    end
  end

  assign counted_o                = counted;
  assign group_done_o             = done;
  assign sums_o.total_bytes       = 32'(total_n);
  assign sums_o.byte_sum          = vsum_n;
  assign sums_o.byte_square_sum   = ssum_n;
  assign sums_o.circular_lag_sum  = lag_n + 48'(wrap_term);
  assign sums_o.full_res          = full_n;

  always_ff @(posedge clk_i) begin
    if (step_i.fire && counted) begin
      grp_q[pos_b] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      vsum_q  <= '0;
      ssum_q  <= '0;
      lag_q   <= '0;
      pend_q  <= 1'b1;
      first_q <= '0;
      prev_q  <= '0;
      full_q  <= 1'b0;
      pos_q   <= '0;
    end else if (step_i.fire) begin
      total_q <= total_n;
      vsum_q  <= vsum_n;
      ssum_q  <= ssum_n;
      lag_q   <= lag_n;
      pend_q  <= pend_n;
      first_q <= first_n;
      prev_q  <= prev_n;
      full_q  <= full_n;
      pos_q   <= pos_n;
    end
  end

endmodule

// ===== rtl/core/brs_monte.sv =====
// Monte Carlo circle test: registered squares, then compare and trial/hit counters.
module brs_monte #(
  parameter int unsigned GROUP_BYTES = brs_pkg::GroupBytes,
  localparam int unsigned HalfBytes  = GROUP_BYTES / 2,
  localparam int unsigned CoordBits  = 8 * HalfBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  input  logic                 done_i,
  input  logic                 restart_i,
  input  logic                 advance_i,
  output logic [29:0]          trials_o,
  output logic [29:0]          hits_o
);

  localparam int unsigned SqBits = 2 * CoordBits;
  localparam logic [SqBits-1:0] RadiusSq =
    {{(CoordBits-1){1'b1}}, 1'b0, {(CoordBits-1){1'b0}}, 1'b1};

  logic [SqBits-1:0] xx_d, yy_d, xx_q, yy_q;
  logic              done_q, restart_q, in_circle;
  logic [29:0]       trials_q, hits_q;

  assign xx_d = x_i * x_i;
  assign yy_d = y_i * y_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      xx_q      <= xx_d;
      yy_q      <= yy_d;
      done_q    <= done_i;
      restart_q <= restart_i;
    end
  end

  assign in_circle = ({1'b0, xx_q} + {1'b0, yy_q}) <= {1'b0, RadiusSq};
  assign trials_o  = (restart_q ? 30'd0 : trials_q) + 30'(done_q);
  assign hits_o    = (restart_q ? 30'd0 : hits_q) + 30'(done_q && in_circle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trials_q <= '0;
      hits_q   <= '0;
    end else if (advance_i) begin
      trials_q <= trials_o;
      hits_q   <= hits_o;
    end
  end

endmodule

// ===== rtl/core/byte_randomness_statistics.sv =====
// Byte randomness statistics: histogram and running sums, one result item per byte.
// A byte passes through stage 1, stage 2 (its sums and histogram term) and then the output register.
// Throughput: one item per cycle while the output is not stalled; the histogram read-modify-write forwards the
// last written count so equal bytes in adjacent cycles count correctly.
// The whole pipeline holds while the output item is stalled.
// Reset clears all sums and marks every histogram bin empty at once; no clearing pass.
module byte_randomness_statistics #(
  parameter int unsigned GROUP_BYTES = brs_pkg::GroupBytes,
  parameter int unsigned COUNT_BITS  = brs_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brs_pkg::out_item_t out_item_o
);

  localparam int unsigned CoordBits = 8 * (GROUP_BYTES / 2);

  logic               adv;
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  brs_pkg::in_item_t  s1_item_q;
  brs_pkg::sums_t     sums, s2_sums_q;
  logic [63:0]        bin_sq, s2_bin_sq_q;
  brs_pkg::step_t     step;
  logic               counted, group_done;
  logic [CoordBits-1:0] coord_x, coord_y;
  logic [29:0]        trials, hits;
  logic [7:0]         rd_addr;
  brs_pkg::out_item_t out_item_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign rd_addr    = adv ? in_item_i.data_byte : s1_item_q.data_byte;

  assign step.fire      = adv && s1_valid_q;
  assign step.restart   = s1_item_q.restart;
  assign step.data_byte = s1_item_q.data_byte;

  brs_hist #(
    .COUNT_BITS(COUNT_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .step_i    (step),
    .counted_i (counted),
    .bin_sq_o  (bin_sq)
  );

  brs_stats #(
    .GROUP_BYTES(GROUP_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .counted_o    (counted),
    .sums_o       (sums),
    .x_o          (coord_x),
    .y_o          (coord_y),
    .group_done_o (group_done)
  );

  brs_monte #(
    .GROUP_BYTES(GROUP_BYTES)
  ) u_monte (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step.fire),
    .x_i       (coord_x),
    .y_i       (coord_y),
    .done_i    (group_done),
    .restart_i (step.restart),
    .advance_i (adv && s2_valid_q),
    .trials_o  (trials),
    .hits_o    (hits)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q                   <= in_item_i;
      s2_sums_q                   <= sums;
      s2_bin_sq_q                 <= bin_sq;
      out_item_q.total_bytes      <= s2_sums_q.total_bytes;
      out_item_q.byte_sum         <= s2_sums_q.byte_sum;
      out_item_q.byte_square_sum  <= s2_sums_q.byte_square_sum;
      out_item_q.circular_lag_sum <= s2_sums_q.circular_lag_sum;
      out_item_q.bin_square_sum   <= s2_bin_sq_q;
      out_item_q.monte_trials     <= trials;
      out_item_q.monte_hits       <= hits;
      out_item_q.full_res         <= s2_sums_q.full_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for byte_randomness_statistics with an in-bench statistics predictor.
module tb;

  localparam int unsigned CountBitsTb = 16;
  localparam longint unsigned CountMax = (64'd1 << CountBitsTb) - 64'd1;
  localparam int unsigned HalfGroup = brs_pkg::GroupBytes / 2;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReports = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  brs_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  brs_pkg::out_item_t out_item_o;

  byte_randomness_statistics #(
    .COUNT_BITS(CountBitsTb)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  logic [31:0] bin_count [brs_pkg::BinCount];
  logic [31:0] stat_total;
  logic [7:0]  group_buf [brs_pkg::GroupBytes];
  int unsigned group_pos;
  logic [29:0] stat_trials;
  logic [29:0] stat_hits;
  logic        first_pending;
  logic [7:0]  first_byte;
  logic [7:0]  prev_byte;
  logic [40:0] stat_sum;
  logic [48:0] stat_sq_sum;
  logic [48:0] stat_lag_sum;
  logic [63:0] stat_bin_sq;
  logic        stat_full;

  brs_pkg::out_item_t pending_stats [$];
  int unsigned gap_pct = 14;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  last_sent = 8'h00;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_stats();
    for (int i = 0; i < brs_pkg::BinCount; i++) bin_count[i] = '0;
    for (int i = 0; i < brs_pkg::GroupBytes; i++) group_buf[i] = '0;
    stat_total    = '0;
    group_pos     = 0;
    stat_trials   = '0;
    stat_hits     = '0;
    first_pending = 1'b1;
    first_byte    = '0;
    prev_byte     = '0;
    stat_sum      = '0;
    stat_sq_sum   = '0;
    stat_lag_sum  = '0;
    stat_bin_sq   = '0;
    stat_full     = 1'b0;
  endfunction

  function automatic brs_pkg::out_item_t advance_stats(brs_pkg::in_item_t it);
    brs_pkg::out_item_t res;
    logic [7:0]  b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] rr;
    logic [48:0] lag_wrap;
    b = it.data_byte;
    if (it.restart) clear_stats();
    if (!stat_full) begin
      stat_bin_sq = stat_bin_sq + 64'(bin_count[b]) * 64'd2 + 64'd1;
      bin_count[b] = bin_count[b] + 32'd1;
      stat_total = stat_total + 32'd1;
      group_buf[group_pos] = b;
      group_pos++;
      if (group_pos >= brs_pkg::GroupBytes) begin
        group_pos = 0;
        x = '0;
        y = '0;
        for (int k = 0; k < HalfGroup; k++) begin
          x = (x << 8) | 64'(group_buf[k]);
          y = (y << 8) | 64'(group_buf[HalfGroup + k]);
        end
        rr = ((64'd1 << (8 * HalfGroup)) - 64'd1);
        rr = rr * rr;
        stat_trials = stat_trials + 30'd1;
        if (y * y <= rr - x * x) stat_hits = stat_hits + 30'd1;
      end
      if (first_pending) begin
        first_pending = 1'b0;
        first_byte = b;
      end else begin
        stat_lag_sum = stat_lag_sum + 49'(prev_byte) * 49'(b);
      end
      stat_sum = stat_sum + 41'(b);
      stat_sq_sum = stat_sq_sum + 49'(b) * 49'(b);
      prev_byte = b;
      if (64'(stat_total) >= CountMax) stat_full = 1'b1;
    end
    lag_wrap = stat_lag_sum + 49'(prev_byte) * 49'(first_byte);
    res.total_bytes      = stat_total;
    res.byte_sum         = stat_sum[39:0];
    res.byte_square_sum  = stat_sq_sum[47:0];
    res.circular_lag_sum = lag_wrap[47:0];
    res.bin_square_sum   = stat_bin_sq;
    res.monte_trials     = stat_trials;
    res.monte_hits       = stat_hits;
    res.full_res         = stat_full;
    return res;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic rs);
    brs_pkg::in_item_t it;
    it.data_byte = b;
    it.restart   = rs;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_stats.push_back(advance_stats(it));
    last_sent = b;
    n_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MaxReports)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 n_checked, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (gap_pct != 0 && $urandom_range(99) < gap_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) $display("result item with none expected");
      end else begin
        brs_pkg::out_item_t want;
        want = pending_stats.pop_front();
        check_field("total_bytes", 64'(want.total_bytes), 64'(out_item_o.total_bytes));
        check_field("byte_sum", 64'(want.byte_sum), 64'(out_item_o.byte_sum));
        check_field("byte_square_sum", 64'(want.byte_square_sum),
                    64'(out_item_o.byte_square_sum));
        check_field("circular_lag_sum", 64'(want.circular_lag_sum),
                    64'(out_item_o.circular_lag_sum));
        check_field("bin_square_sum", want.bin_square_sum, out_item_o.bin_square_sum);
        check_field("monte_trials", 64'(want.monte_trials), 64'(out_item_o.monte_trials));
        check_field("monte_hits", 64'(want.monte_hits), 64'(out_item_o.monte_hits));
        check_field("full_res", 64'(want.full_res), 64'(out_item_o.full_res));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic test_extremes_and_restart();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
  endtask

  task automatic test_monte_boundaries();
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    repeat (6) send_byte(8'hFF, 1'b0);
    repeat (6) send_byte(8'h00, 1'b0);
  endtask

  task automatic test_random_stream(input int unsigned count);
    logic [7:0] b;
    logic       rs;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 3) gap_pct = 0;
      if (i == count / 2) gap_pct = 14;
      if (i == (2 * count) / 3) wait_for_drain();
      case ($urandom_range(9))
        4, 5:    b = last_sent;
        6:       b = $urandom_range(1) ? 8'hFF : 8'h00;
        7:       b = $urandom_range(1) ? 8'($urandom_range(255, 240)) : 8'($urandom_range(15));
        default: b = 8'($urandom_range(255));
      endcase
      rs = ($urandom_range(99) < 3);
      send_byte(b, rs);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_stall_i <= 1'b0;
    clear_stats();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes_and_restart();
    test_monte_boundaries();
    test_random_stream(1927);
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes: extremes, restarts, circle-boundary groups, random streams",
             n_sent);
    $display("with repeats, idle-free bursts and a full drain; %0d results, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0 && pending_stats.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
